// ----- src/rotor_cipher_engine_macros.svh -----
// Assertion helpers used by the rotor cipher engine RTL.
`ifndef ROTOR_CIPHER_ENGINE_MACROS_SVH
`define ROTOR_CIPHER_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rce_pkg.sv -----
package rce_pkg;

  localparam int MAX_ROTORS   = 8;
  localparam int MAX_ALPHABET = 256;

  localparam int SYM_W    = 8;
  localparam int SIZE_W   = 9;
  localparam int ROT_W    = $clog2(MAX_ROTORS);
  localparam int NROT_W   = 4;
  localparam int SEL_W    = 3;
  localparam int CMD_W    = 2;
  localparam int STS_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int WIRE_AW  = ROT_W + SYM_W;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_ALPHABET);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [NROT_W-1:0] NROT_MAX   = NROT_W'(MAX_ROTORS);
  localparam logic [NROT_W-1:0] NROT_RESET = NROT_W'(3);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENCRYPT = 2'd0,
    CMD_PLUG    = 2'd1,
    CMD_REFL    = 2'd2,
    CMD_ROTOR   = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 2'd0,
    STS_RANGE  = 2'd1,
    STS_NO_INV = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHABET_SIZE = 1'b0,
    CFG_ROTORS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PLUG_RD,
    OP_PLUG_LD,
    OP_FWD_START,
    OP_FWD_RD,
    OP_FWD_LD,
    OP_REFL_RD,
    OP_REFL_LD,
    OP_BWD_START,
    OP_SRCH_INIT,
    OP_SRCH,
    OP_STEP_START,
    OP_STEP_WR,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PLUG_IN_RD,
    S_PLUG_IN_LD,
    S_FWD_START,
    S_FWD_WAIT,
    S_FWD_RD,
    S_FWD_LD,
    S_REFL_RD,
    S_REFL_LD,
    S_BWD_START,
    S_BWD_WAIT,
    S_SRCH_INIT,
    S_SRCH,
    S_PLUG_OUT_RD,
    S_PLUG_OUT_LD,
    S_STEP_START,
    S_STEP_WAIT,
    S_STEP_WR,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic val_oor;
    logic is_load;
    logic mod_busy;
    logic mod_done;
    logic rot_first;
    logic rot_last;
    logic hit;
    logic miss;
    logic carry;
  } dp_sts_t;

endpackage

// ----- src/rce_if.sv -----
interface rce_in_if;
  logic                       valid;
  logic                       ready;
  logic [rce_pkg::CMD_W-1:0]  cmd;
  logic [rce_pkg::SYM_W-1:0]  value;
  logic [rce_pkg::SYM_W-1:0]  entry;
  logic [rce_pkg::SEL_W-1:0]  rotor_select;

  modport source (output valid, cmd, value, entry, rotor_select, input ready);
  modport sink   (input valid, cmd, value, entry, rotor_select, output ready);
endinterface

interface rce_out_if;
  logic                       valid;
  logic                       ready;
  logic [rce_pkg::SYM_W-1:0]  cipher_symbol;
  logic [rce_pkg::STS_W-1:0]  status;

  modport source (output valid, cipher_symbol, status, input ready);
  modport sink   (input valid, cipher_symbol, status, output ready);
endinterface

// ----- src/rce_mod.sv -----
// Serial restoring remainder: one dividend bit per cycle.
module rce_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rce_pkg::SIZE_W-1:0]  dividend_i,
  input  logic [rce_pkg::SIZE_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [rce_pkg::SYM_W-1:0]   rem_o
);

  localparam int CNT_W = $clog2(rce_pkg::SIZE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rce_pkg::SIZE_W - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [rce_pkg::SIZE_W-1:0] dvd_q, dvd_d;
  logic [rce_pkg::SIZE_W-1:0] rem_q, rem_d;
  logic [rce_pkg::SIZE_W:0]   trial;
  logic                       ge;

  assign trial = {rem_q, dvd_q[rce_pkg::SIZE_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rce_pkg::SIZE_W'(trial - {1'b0, divisor_i}) : trial[rce_pkg::SIZE_W-1:0];
      dvd_d = {dvd_q[rce_pkg::SIZE_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q[rce_pkg::SYM_W-1:0];

endmodule

// ----- src/rce_datapath.sv -----
module rce_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [rce_pkg::CMD_W-1:0]      in_cmd_i,
  input  logic [rce_pkg::SYM_W-1:0]      in_value_i,
  input  logic [rce_pkg::SYM_W-1:0]      in_entry_i,
  input  logic [rce_pkg::SEL_W-1:0]      in_sel_i,
  input  rce_pkg::dp_cmd_t               dp_cmd_i,
  output rce_pkg::dp_sts_t               dp_sts_o,
  output logic [rce_pkg::SYM_W-1:0]      res_symbol_o,
  output logic [rce_pkg::STS_W-1:0]      res_status_o
);

  localparam int SW = rce_pkg::SYM_W;
  localparam int ZW = rce_pkg::SIZE_W;
  localparam int RW = rce_pkg::ROT_W;
  localparam int NW = rce_pkg::NROT_W;

  // configuration
  logic [ZW-1:0] size_cfg_q;
  logic [NW-1:0] nrot_cfg_q;
  logic [ZW-1:0] size_eff;
  logic [NW-1:0] nrot_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= rce_pkg::SIZE_RESET;
      nrot_cfg_q <= rce_pkg::NROT_RESET;
    end else if (cfg_we_i) begin
      unique case (rce_pkg::cfg_idx_e'(cfg_idx_i))
        rce_pkg::CFG_ALPHABET_SIZE: size_cfg_q <= cfg_wdata_i[ZW-1:0];
        rce_pkg::CFG_ROTORS_IN_USE: nrot_cfg_q <= cfg_wdata_i[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_cfg_q < rce_pkg::SIZE_MIN)      size_eff = rce_pkg::SIZE_MIN;
    else if (size_cfg_q > rce_pkg::SIZE_MAX) size_eff = rce_pkg::SIZE_MAX;
    else                                     size_eff = size_cfg_q;
    if (nrot_cfg_q == '0)                    nrot_eff = NW'(1);
    else if (nrot_cfg_q > rce_pkg::NROT_MAX) nrot_eff = rce_pkg::NROT_MAX;
    else                                     nrot_eff = nrot_cfg_q;
  end

  // working registers
  logic [SW-1:0] sym_q;
  logic [RW-1:0] rot_q;
  logic [SW-1:0] pm_q;
  logic [ZW-1:0] idx_q;
  logic [SW-1:0] cmp_q;
  logic          pend_q;
  logic          carry_q;
  logic [SW-1:0] pos_q [rce_pkg::MAX_ROTORS];
  logic [SW-1:0] res_sym_q;
  logic [rce_pkg::STS_W-1:0] res_sts_q;

  rce_pkg::dp_op_e op;
  assign op = dp_cmd_i.op;

  // tables
  logic [SW-1:0] plug_mem [rce_pkg::MAX_ALPHABET];
  logic [SW-1:0] refl_mem [rce_pkg::MAX_ALPHABET];
  logic [SW-1:0] wire_mem [rce_pkg::MAX_ROTORS * rce_pkg::MAX_ALPHABET];
  logic [SW-1:0] plug_rdata_q, refl_rdata_q, wire_rdata_q;
  logic [rce_pkg::WIRE_AW-1:0] wire_raddr;

  logic is_load, accept;
  logic plug_we, refl_we, wire_we;

  assign accept  = op == rce_pkg::OP_ACCEPT;
  assign is_load = in_cmd_i != rce_pkg::CMD_ENCRYPT;
  assign plug_we = accept && in_cmd_i == rce_pkg::CMD_PLUG;
  assign refl_we = accept && in_cmd_i == rce_pkg::CMD_REFL;
  assign wire_we = accept && in_cmd_i == rce_pkg::CMD_ROTOR;

  // serial remainder unit
  logic          mod_start, mod_busy, mod_done;
  logic [ZW-1:0] mod_dvd;
  logic [SW-1:0] mod_rem;

  always_comb begin
    mod_start = 1'b0;
    mod_dvd   = '0;
    unique case (op)
      rce_pkg::OP_FWD_START: begin
        mod_start = 1'b1;
        mod_dvd   = {1'b0, sym_q} + {1'b0, pos_q[rot_q]};
      end
      rce_pkg::OP_BWD_START: begin
        mod_start = 1'b1;
        mod_dvd   = {1'b0, pos_q[rot_q]};
      end
      rce_pkg::OP_STEP_START: begin
        mod_start = 1'b1;
        mod_dvd   = {1'b0, pos_q[rot_q]} + ZW'(1);
      end
      default: ;
    endcase
  end

  rce_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (size_eff),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // wiring search: each address is compared in the cycle after it is issued
  logic          issue, hit, miss;
  logic [ZW:0]   back_sum;
  logic [SW-1:0] back_sym;

  assign issue = idx_q < size_eff;
  assign hit   = pend_q && (wire_rdata_q == sym_q);
  assign miss  = pend_q && !hit && ({1'b0, cmp_q} == size_eff - ZW'(1));

  // at and pm are both below size, so one correction suffices
  assign back_sum = {2'b0, cmp_q} + {1'b0, size_eff} - {2'b0, pm_q};
  assign back_sym = (back_sum >= {1'b0, size_eff}) ?
                    SW'(back_sum - {1'b0, size_eff}) : back_sum[SW-1:0];

  always_comb begin
    if (op == rce_pkg::OP_SRCH) wire_raddr = {rot_q, idx_q[SW-1:0]};
    else                        wire_raddr = {rot_q, mod_rem};
  end

  always_ff @(posedge clk_i) begin
    if (plug_we) plug_mem[in_entry_i] <= in_value_i;
    plug_rdata_q <= plug_mem[sym_q];
  end

  always_ff @(posedge clk_i) begin
    if (refl_we) refl_mem[in_entry_i] <= in_value_i;
    refl_rdata_q <= refl_mem[sym_q];
  end

  always_ff @(posedge clk_i) begin
    if (wire_we) wire_mem[{in_sel_i[RW-1:0], in_entry_i}] <= in_value_i;
    wire_rdata_q <= wire_mem[wire_raddr];
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      pend_q  <= 1'b0;
      carry_q <= 1'b0;
      for (int i = 0; i < rce_pkg::MAX_ROTORS; i++) pos_q[i] <= '0;
    end else begin
      unique case (op)
        rce_pkg::OP_ACCEPT, rce_pkg::OP_PLUG_LD: rot_q <= '0;
        rce_pkg::OP_FWD_LD:  rot_q <= rot_q + RW'(1);
        rce_pkg::OP_REFL_LD: rot_q <= RW'(nrot_eff - NW'(1));
        rce_pkg::OP_SRCH_INIT: pend_q <= 1'b0;
        rce_pkg::OP_SRCH: begin
          pend_q <= issue;
          if (hit) rot_q <= rot_q - RW'(1);
        end
        rce_pkg::OP_STEP_START:
          carry_q <= {1'b0, pos_q[rot_q]} >= size_eff - ZW'(1);
        rce_pkg::OP_STEP_WR: begin
          pos_q[rot_q] <= mod_rem;
          rot_q        <= rot_q + RW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (op)
      rce_pkg::OP_ACCEPT:  sym_q <= is_load ? '0 : in_value_i;
      rce_pkg::OP_PLUG_LD: sym_q <= plug_rdata_q;
      rce_pkg::OP_FWD_LD:  sym_q <= wire_rdata_q;
      rce_pkg::OP_REFL_LD: sym_q <= refl_rdata_q;
      rce_pkg::OP_SRCH_INIT: begin
        pm_q  <= mod_rem;
        idx_q <= '0;
      end
      rce_pkg::OP_SRCH: begin
        cmp_q <= idx_q[SW-1:0];
        if (issue) idx_q <= idx_q + ZW'(1);
        if (hit)   sym_q <= back_sym;
      end
      rce_pkg::OP_RESULT: begin
        res_sym_q <= (dp_cmd_i.res_status == rce_pkg::STS_OK) ? sym_q : '0;
        res_sts_q <= dp_cmd_i.res_status;
      end
      default: ;
    endcase
  end

  always_comb begin
    dp_sts_o.val_oor   = {1'b0, in_value_i} >= size_eff;
    dp_sts_o.is_load   = is_load;
    dp_sts_o.mod_busy  = mod_busy;
    dp_sts_o.mod_done  = mod_done;
    dp_sts_o.rot_first = rot_q == '0;
    dp_sts_o.rot_last  = {1'b0, rot_q} == nrot_eff - NW'(1);
    dp_sts_o.hit       = hit;
    dp_sts_o.miss      = miss;
    dp_sts_o.carry     = carry_q;
  end

  assign res_symbol_o = res_sym_q;
  assign res_status_o = res_sts_q;

endmodule

// ----- src/rce_ctrl.sv -----
`include "rotor_cipher_engine_macros.svh"

module rce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rce_pkg::dp_cmd_t  dp_cmd_o,
  input  rce_pkg::dp_sts_t  dp_sts_i
);

  rce_pkg::ctrl_state_e state_q, state_d;
  rce_pkg::status_e     res_q, res_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rce_pkg::S_IDLE;
      res_q       <= rce_pkg::STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    dp_cmd_o.op = rce_pkg::OP_NONE;
    dp_cmd_o.res_status = res_q;
    unique case (state_q)
      rce_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.op = rce_pkg::OP_ACCEPT;
          if (dp_sts_i.is_load) begin
            res_d   = rce_pkg::STS_OK;
            state_d = rce_pkg::S_RESULT;
          end else if (dp_sts_i.val_oor) begin
            res_d   = rce_pkg::STS_RANGE;
            state_d = rce_pkg::S_RESULT;
          end else begin
            state_d = rce_pkg::S_PLUG_IN_RD;
          end
        end
      end
      rce_pkg::S_PLUG_IN_RD: begin
        dp_cmd_o.op = rce_pkg::OP_PLUG_RD;
        state_d     = rce_pkg::S_PLUG_IN_LD;
      end
      rce_pkg::S_PLUG_IN_LD: begin
        dp_cmd_o.op = rce_pkg::OP_PLUG_LD;
        state_d     = rce_pkg::S_FWD_START;
      end
      rce_pkg::S_FWD_START: begin
        dp_cmd_o.op = rce_pkg::OP_FWD_START;
        state_d     = rce_pkg::S_FWD_WAIT;
      end
      rce_pkg::S_FWD_WAIT: begin
        if (dp_sts_i.mod_done) state_d = rce_pkg::S_FWD_RD;
      end
      rce_pkg::S_FWD_RD: begin
        dp_cmd_o.op = rce_pkg::OP_FWD_RD;
        state_d     = rce_pkg::S_FWD_LD;
      end
      rce_pkg::S_FWD_LD: begin
        dp_cmd_o.op = rce_pkg::OP_FWD_LD;
        state_d     = dp_sts_i.rot_last ? rce_pkg::S_REFL_RD : rce_pkg::S_FWD_START;
      end
      rce_pkg::S_REFL_RD: begin
        dp_cmd_o.op = rce_pkg::OP_REFL_RD;
        state_d     = rce_pkg::S_REFL_LD;
      end
      rce_pkg::S_REFL_LD: begin
        dp_cmd_o.op = rce_pkg::OP_REFL_LD;
        state_d     = rce_pkg::S_BWD_START;
      end
      rce_pkg::S_BWD_START: begin
        dp_cmd_o.op = rce_pkg::OP_BWD_START;
        state_d     = rce_pkg::S_BWD_WAIT;
      end
      rce_pkg::S_BWD_WAIT: begin
        if (dp_sts_i.mod_done) state_d = rce_pkg::S_SRCH_INIT;
      end
      rce_pkg::S_SRCH_INIT: begin
        dp_cmd_o.op = rce_pkg::OP_SRCH_INIT;
        state_d     = rce_pkg::S_SRCH;
      end
      rce_pkg::S_SRCH: begin
        dp_cmd_o.op = rce_pkg::OP_SRCH;
        if (dp_sts_i.hit) begin
          state_d = dp_sts_i.rot_first ? rce_pkg::S_PLUG_OUT_RD : rce_pkg::S_BWD_START;
        end else if (dp_sts_i.miss) begin
          res_d   = rce_pkg::STS_NO_INV;
          state_d = rce_pkg::S_RESULT;
        end
      end
      rce_pkg::S_PLUG_OUT_RD: begin
        dp_cmd_o.op = rce_pkg::OP_PLUG_RD;
        state_d     = rce_pkg::S_PLUG_OUT_LD;
      end
      rce_pkg::S_PLUG_OUT_LD: begin
        dp_cmd_o.op = rce_pkg::OP_PLUG_LD;
        state_d     = rce_pkg::S_STEP_START;
      end
      rce_pkg::S_STEP_START: begin
        dp_cmd_o.op = rce_pkg::OP_STEP_START;
        state_d     = rce_pkg::S_STEP_WAIT;
      end
      rce_pkg::S_STEP_WAIT: begin
        if (dp_sts_i.mod_done) state_d = rce_pkg::S_STEP_WR;
      end
      rce_pkg::S_STEP_WR: begin
        dp_cmd_o.op = rce_pkg::OP_STEP_WR;
        if (dp_sts_i.carry && !dp_sts_i.rot_last) begin
          state_d = rce_pkg::S_STEP_START;
        end else begin
          res_d   = rce_pkg::STS_OK;
          state_d = rce_pkg::S_RESULT;
        end
      end
      rce_pkg::S_RESULT: begin
        // output slot frees up when the pending beat is taken
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.op = rce_pkg::OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = rce_pkg::S_IDLE;
        end
      end
      default: state_d = rce_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `RCE_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != rce_pkg::S_IDLE, "accepted beat did not start work")
  `RCE_ASSERT_NEXT(a_result_loads_out, clk_i, rst_ni, dp_cmd_o.op == rce_pkg::OP_RESULT, out_valid_q, "result not presented")
  `RCE_ASSERT_SAME(a_idle_mod_quiet, clk_i, rst_ni, state_q == rce_pkg::S_IDLE, !dp_sts_i.mod_busy, "remainder unit busy while idle")

endmodule

// ----- src/rotor_cipher_engine.sv -----
// Rotor cipher engine: one result beat per input beat. Load commands and
// out-of-range symbols go straight to the result. On the way back, each
// rotor's wiring memory is scanned one entry per cycle for the matching
// entry, and the rotors in use advance like an odometer after a
// successful encrypt. Each rotor offset and position update goes through
// a shared serial remainder unit of nine shift steps. One item is in work
// at a time; a finished result waits in the output register while the
// next item is accepted. Configuration may be written only while the
// block is idle.
module rotor_cipher_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rce_in_if.sink                         in_i,
  rce_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  rce_pkg::dp_cmd_t dp_cmd;
  rce_pkg::dp_sts_t dp_sts;

  rce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  rce_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (in_i.cmd),
    .in_value_i   (in_i.value),
    .in_entry_i   (in_i.entry),
    .in_sel_i     (in_i.rotor_select),
    .dp_cmd_i     (dp_cmd),
    .dp_sts_o     (dp_sts),
    .res_symbol_o (out_o.cipher_symbol),
    .res_status_o (out_o.status)
  );

endmodule

// ----- tb/rotor_cipher_engine_test.sv -----
`timescale 1ns / 100ps
module rotor_cipher_engine_test;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES = 400;

  typedef logic [rce_pkg::SYM_W-1:0] sym_t;
  typedef logic [rce_pkg::SEL_W-1:0] sel_t;

  typedef struct {
    sym_t             sym;
    rce_pkg::status_e sts;
  } cipher_res_t;

  class cipher_scoreboard;
    sym_t plug[rce_pkg::MAX_ALPHABET];
    sym_t refl[rce_pkg::MAX_ALPHABET];
    sym_t wiring[rce_pkg::MAX_ROTORS][rce_pkg::MAX_ALPHABET];
    sym_t pos[rce_pkg::MAX_ROTORS];
    int unsigned size_reg = 256;
    int unsigned rot_reg = 3;
    cipher_res_t expected_q[$];
    int fails = 0;

    function new();
      foreach (pos[i]) pos[i] = '0;
    endfunction

    function void write_reg(rce_pkg::cfg_idx_e idx, logic [rce_pkg::CFG_DATA_W-1:0] d);
      if (idx == rce_pkg::CFG_ALPHABET_SIZE) size_reg = 32'(d);
      else rot_reg = 32'(d[rce_pkg::NROT_W-1:0]);
    endfunction

    function cipher_res_t encipher(sym_t v);
      cipher_res_t res;
      int unsigned sz, n, s, p, at;
      bit found, carry;
      res.sym = '0;
      res.sts = rce_pkg::STS_OK;
      sz = size_reg < 2 ? 2 :
           (size_reg > rce_pkg::MAX_ALPHABET ? rce_pkg::MAX_ALPHABET : size_reg);
      n = rot_reg < 1 ? 1 : (rot_reg > rce_pkg::MAX_ROTORS ? rce_pkg::MAX_ROTORS : rot_reg);
      if (32'(v) >= sz) begin
        res.sts = rce_pkg::STS_RANGE;
        return res;
      end
      s = 32'(plug[v]);
      for (int r = 0; r < n; r++) s = 32'(wiring[r][(s + 32'(pos[r])) % sz]);
      s = 32'(refl[s]);
      for (int r = int'(n) - 1; r >= 0; r--) begin
        p = 32'(pos[r]) % sz;
        found = 1'b0;
        at = 0;
        for (int i = 0; i < sz; i++) begin
          if (32'(wiring[r][i]) == s) begin
            found = 1'b1;
            at = unsigned'(i);
            break;
          end
        end
        if (!found) begin
          res.sts = rce_pkg::STS_NO_INV;
          return res;
        end
        s = (at + sz - p) % sz;
      end
      s = 32'(plug[s]);
      // odometer: a rotor at its last position carries into the next one
      carry = 1'b1;
      for (int r = 0; r < n && carry; r++) begin
        p = 32'(pos[r]);
        carry = (p >= sz - 1);
        pos[r] = sym_t'((p + 1) % sz);
      end
      res.sym = sym_t'(s);
      return res;
    endfunction

    function void note_input(rce_pkg::cmd_e c, sym_t v, sym_t e, sel_t sel);
      cipher_res_t res;
      res.sym = '0;
      res.sts = rce_pkg::STS_OK;
      case (c)
        rce_pkg::CMD_PLUG:  plug[e] = v;
        rce_pkg::CMD_REFL:  refl[e] = v;
        rce_pkg::CMD_ROTOR: wiring[sel][e] = v;
        default:            res = encipher(v);
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(sym_t sym, logic [rce_pkg::STS_W-1:0] sts);
      cipher_res_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: cipher_symbol %0d status %0d", sym, sts);
        fails++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (sym !== exp_res.sym) begin
        $error("cipher_symbol: expected %0d, actual %0d", exp_res.sym, sym);
        fails++;
      end
      if (sts !== exp_res.sts) begin
        $error("status: expected %0d, actual %0d", exp_res.sts, sts);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  rce_pkg::cfg_idx_e cfg_idx = rce_pkg::CFG_ALPHABET_SIZE;
  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  rce_in_if in_ch();
  rce_out_if out_ch();

  cipher_scoreboard sb = new();
  int src_idle = 17;
  int snk_idle = 88;
  int item_count = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  rotor_cipher_engine dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(rce_pkg::cmd_e'(in_ch.cmd), in_ch.value, in_ch.entry,
                      in_ch.rotor_select);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.cipher_symbol, out_ch.status);
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send(rce_pkg::cmd_e c, sym_t v, sym_t e, sel_t sel);
    if (item_count < ITEM_TARGET / 3) begin
      src_idle = 17;
      snk_idle = 88;
    end else if (item_count < 2 * ITEM_TARGET / 3) begin
      src_idle = 88;
      snk_idle = 17;
    end else begin
      src_idle = 0;
      snk_idle = 0;
    end
    if (item_count == 200) hold_req = 1'b1;
    item_count++;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.value        <= v;
    in_ch.entry        <= e;
    in_ch.rotor_select <= sel;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(rce_pkg::cfg_idx_e idx, logic [rce_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic load_perm(rce_pkg::cmd_e c, sel_t sel, int sz);
    sym_t perm[rce_pkg::MAX_ALPHABET];
    sym_t t;
    int j;
    for (int i = 0; i < sz; i++) perm[i] = sym_t'(i);
    for (int i = sz - 1; i > 0; i--) begin
      j = int'($urandom_range(unsigned'(i)));
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < sz; i++) send(c, perm[i], sym_t'(i), sel);
  endtask

  // idle block: set both registers, then rewire the used entries as permutations
  task automatic setup_phase(int sz_val, int rot_val);
    int sz, n;
    drain();
    write_reg(rce_pkg::CFG_ALPHABET_SIZE, rce_pkg::CFG_DATA_W'(sz_val));
    write_reg(rce_pkg::CFG_ROTORS_IN_USE, rce_pkg::CFG_DATA_W'(rot_val));
    sz = sz_val < 2 ? 2 : (sz_val > rce_pkg::MAX_ALPHABET ? rce_pkg::MAX_ALPHABET : sz_val);
    n = (rot_val % 16) < 1 ? 1 :
        ((rot_val % 16) > rce_pkg::MAX_ROTORS ? rce_pkg::MAX_ROTORS : rot_val % 16);
    load_perm(rce_pkg::CMD_PLUG, '0, sz);
    load_perm(rce_pkg::CMD_REFL, '0, sz);
    for (int r = 0; r < n; r++) load_perm(rce_pkg::CMD_ROTOR, sel_t'(r), sz);
  endtask

  task automatic random_items(int count, int sz);
    int k;
    for (int i = 0; i < count; i++) begin
      k = int'($urandom_range(99));
      if (k < 6)
        send(rce_pkg::cmd_e'(rce_pkg::CMD_W'($urandom_range(3, 1))),
             sym_t'($urandom_range(255)), sym_t'($urandom_range(255)),
             sel_t'($urandom_range(7)));
      else if (k < 12)
        send(rce_pkg::CMD_ENCRYPT, sym_t'($urandom_range(255)),
             sym_t'($urandom_range(255)), sel_t'($urandom_range(7)));
      else
        send(rce_pkg::CMD_ENCRYPT, sym_t'($urandom_range(unsigned'(sz - 1))),
             sym_t'($urandom_range(255)), sel_t'($urandom_range(7)));
    end
  endtask

  initial begin
    int sz, rn;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = rce_pkg::CMD_ENCRYPT;
    in_ch.value        = '0;
    in_ch.entry        = '0;
    in_ch.rotor_select = '0;
    out_ch.ready       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // plugboard and reflector are filled completely, so any table value
    // used as an index reads a written entry
    load_perm(rce_pkg::CMD_PLUG, '0, rce_pkg::MAX_ALPHABET);
    load_perm(rce_pkg::CMD_REFL, '0, rce_pkg::MAX_ALPHABET);
    load_perm(rce_pkg::CMD_ROTOR, '0, rce_pkg::MAX_ALPHABET);

    // full alphabet, one rotor
    drain();
    write_reg(rce_pkg::CFG_ROTORS_IN_USE, rce_pkg::CFG_DATA_W'(1));
    random_items(30, rce_pkg::MAX_ALPHABET);
    drain();
    write_reg(rce_pkg::CFG_ALPHABET_SIZE, rce_pkg::CFG_DATA_W'(511));
    write_reg(rce_pkg::CFG_ROTORS_IN_USE, rce_pkg::CFG_DATA_W'(0));
    random_items(20, rce_pkg::MAX_ALPHABET);

    setup_phase(10, 2);
    send(rce_pkg::CMD_ENCRYPT, 8'd0, 8'd0, 3'd0);
    send(rce_pkg::CMD_ENCRYPT, 8'd9, 8'd255, 3'd7);
    send(rce_pkg::CMD_ENCRYPT, 8'd10, 8'd0, 3'd0);
    send(rce_pkg::CMD_ENCRYPT, 8'd255, 8'd0, 3'd0);
    send(rce_pkg::CMD_ENCRYPT, 8'd5, 8'd0, 3'd0);
    send(rce_pkg::CMD_PLUG, 8'd255, 8'd255, 3'd0);
    send(rce_pkg::CMD_REFL, 8'd0, 8'd255, 3'd7);
    send(rce_pkg::CMD_ROTOR, 8'd0, 8'd255, 3'd7);
    send(rce_pkg::CMD_ENCRYPT, 8'd3, 8'd0, 3'd0);
    // break rotor 0 so some value has no inverse
    send(rce_pkg::CMD_ROTOR, 8'd200, 8'd3, 3'd0);
    for (int v = 0; v < 10; v++) send(rce_pkg::CMD_ENCRYPT, sym_t'(v), 8'd0, 3'd0);

    setup_phase(2, 1);
    random_items(30, 2);
    setup_phase(0, 0);
    random_items(20, 2);
    setup_phase(6, 15);
    random_items(60, 6);
    while (item_count < ITEM_TARGET) begin
      sz = int'($urandom_range(12, 2));
      rn = int'($urandom_range(4, 1));
      setup_phase(sz, rn);
      random_items(30, sz);
    end
    drain();
    if (sb.fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
